// ===== rtl/phag_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak-hang AGC package
// Shared widths, register codes, reset values and types for the peak-hang
// automatic gain control block and its serial arithmetic units.
// ----------------------------------------------------------------------------
package phag_pkg;

    localparam int WINDOW_DEPTH   = 8;
    localparam int IDX_W          = $clog2(WINDOW_DEPTH);
    localparam int LEN_W          = IDX_W + 1;
    localparam int SAMPLE_W       = 16;
    localparam int HANG_W         = 16;
    localparam int RAMP_W         = 18;
    localparam int RAMP_SHIFT     = 16;
    localparam int GAIN_W         = 26;
    localparam int GAIN_FRAC_BITS = 24;
    localparam int GAIN_EXT_W     = GAIN_W + RAMP_W - RAMP_SHIFT;
    localparam int PROD_W         = GAIN_W + RAMP_W;
    localparam int DIVIDEND_W     = GAIN_W + SAMPLE_W;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 26;

    localparam int MUL_STEPS = RAMP_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int DIV_STEPS = GAIN_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HANG_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LIMIT = 3'd4;

    localparam logic [SAMPLE_W-1:0] NOMINAL_RST    = 16'd16384;
    localparam logic [LEN_W-1:0]    WIN_LEN_RST    = 4'd2;
    localparam logic [HANG_W-1:0]   HANG_TICKS_RST = 16'd30;
    localparam logic [RAMP_W-1:0]   RAMP_RST       = 18'd68813;
    localparam logic [GAIN_W-1:0]   GAIN_LIMIT_RST = 26'd33554432;
    localparam logic [GAIN_W-1:0]   GAIN_RST       = GAIN_W'(1) << GAIN_FRAC_BITS;
    localparam logic [HANG_W-1:0]   HANG_MAX       = '1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_st;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SCAN   = 8'b0000_0010,
        ST_DECIDE = 8'b0000_0100,
        ST_MULN   = 8'b0000_1000,
        ST_DIV    = 8'b0001_0000,
        ST_RAMP   = 8'b0010_0000,
        ST_MULR   = 8'b0100_0000,
        ST_FIN    = 8'b1000_0000
    } t_state;

endpackage

// ===== rtl/phag_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak-hang AGC serial multiplier
// Shift-add multiplier that consumes one multiplier bit per cycle, least
// significant first, and shifts the low product bits into the multiplier.
// ----------------------------------------------------------------------------
module phag_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [phag_pkg::GAIN_W-1:0]       i_mcand,
    input  logic [phag_pkg::RAMP_W-1:0]       i_mplier,
    output phag_pkg::t_unit_st                o_st,
    output logic [phag_pkg::PROD_W-1:0]       o_product
);

    logic [phag_pkg::GAIN_W-1:0]    r_acc;
    logic [phag_pkg::RAMP_W-1:0]    r_mq;
    logic [phag_pkg::GAIN_W-1:0]    r_mcand;
    logic [phag_pkg::MUL_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [phag_pkg::GAIN_W:0]      n_sum;
    logic                           n_last;

    assign n_sum  = {1'b0, r_acc} + (r_mq[0] ? {1'b0, r_mcand} : '0);
    assign n_last = (r_cnt == phag_pkg::MUL_CNT_W'(phag_pkg::MUL_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && n_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (n_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc   <= '0;
            r_mq    <= i_mplier;
            r_mcand <= i_mcand;
        end else if (r_busy) begin
            r_acc <= n_sum[phag_pkg::GAIN_W:1];
            r_mq  <= {n_sum[0], r_mq[phag_pkg::RAMP_W-1:1]};
        end
    end

    assign o_st.busy = r_busy;
    assign o_st.done = r_done;
    assign o_product = {r_acc, r_mq};

endmodule

// ===== rtl/phag_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak-hang AGC serial divider
// Restoring divider that produces one quotient bit per cycle. The quotient
// is known to fit the gain width, so the upper dividend bits seed the
// partial remainder directly.
// ----------------------------------------------------------------------------
module phag_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [phag_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  logic [phag_pkg::SAMPLE_W-1:0]       i_divisor,
    output phag_pkg::t_unit_st                  o_st,
    output logic [phag_pkg::GAIN_W-1:0]         o_quotient
);

    logic [phag_pkg::SAMPLE_W-1:0]  r_rem;
    logic [phag_pkg::GAIN_W-1:0]    r_quo;
    logic [phag_pkg::SAMPLE_W-1:0]  r_div;
    logic [phag_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [phag_pkg::SAMPLE_W:0]    n_trial;
    logic [phag_pkg::SAMPLE_W:0]    n_diff;
    logic                           n_ge;
    logic                           n_last;

    assign n_trial = {r_rem, r_quo[phag_pkg::GAIN_W-1]};
    assign n_diff  = n_trial - {1'b0, r_div};
    assign n_ge    = (n_trial >= {1'b0, r_div});
    assign n_last  = (r_cnt == phag_pkg::DIV_CNT_W'(phag_pkg::DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && n_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (n_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[phag_pkg::DIVIDEND_W-1:phag_pkg::GAIN_W];
            r_quo <= i_dividend[phag_pkg::GAIN_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[phag_pkg::SAMPLE_W-1:0] : n_trial[phag_pkg::SAMPLE_W-1:0];
            r_quo <= {r_quo[phag_pkg::GAIN_W-2:0], n_ge};
        end
    end

    assign o_st.busy  = r_busy;
    assign o_st.done  = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/peak_hang_agc_gain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak-hang automatic gain control
// Flow: the window scan reads each active entry; an attack cut then runs the
// serial multiplier and the serial divider, and a ramp runs the serial
// multiplier once more before the gain is clamped and registered.
// Throughput: one transaction at a time; the next is taken the cycle after
// the result is registered. Synchronous active-low reset restores unity gain
// and the register reset values, and clears the window, index and hang count.
// ----------------------------------------------------------------------------
module peak_hang_agc_gain (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [phag_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [phag_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [phag_pkg::SAMPLE_W-1:0]       i_peak_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [phag_pkg::GAIN_W-1:0]         o_gain_out,
    output logic                                o_gain_reduced,
    output logic                                o_gain_ramped
);

    logic [phag_pkg::SAMPLE_W-1:0]   r_nominal;
    logic [phag_pkg::LEN_W-1:0]      r_win_len;
    logic [phag_pkg::HANG_W-1:0]     r_hang_ticks;
    logic [phag_pkg::RAMP_W-1:0]     r_ramp;
    logic [phag_pkg::GAIN_W-1:0]     r_gain_limit;

    phag_pkg::t_state                r_state;
    logic [phag_pkg::GAIN_W-1:0]     r_gain;
    logic [phag_pkg::SAMPLE_W-1:0]   r_window [phag_pkg::WINDOW_DEPTH];
    logic [phag_pkg::IDX_W-1:0]      r_widx;
    logic [phag_pkg::HANG_W-1:0]     r_hang;
    logic [phag_pkg::SAMPLE_W-1:0]   r_sample;
    logic [phag_pkg::IDX_W-1:0]      r_scan;
    logic [phag_pkg::LEN_W-1:0]      r_len;
    logic [phag_pkg::LEN_W-1:0]      r_above;
    logic [phag_pkg::SAMPLE_W-1:0]   r_max;
    logic                            r_reduced;
    logic                            r_ramped;
    logic [phag_pkg::GAIN_EXT_W-1:0] r_ext;
    logic                            r_out_valid;
    logic [phag_pkg::GAIN_W-1:0]     r_out_gain;
    logic                            r_out_reduced;
    logic                            r_out_ramped;

    logic [phag_pkg::LEN_W-1:0]      n_len;
    logic [phag_pkg::LEN_W-1:0]      n_widx_inc;
    logic [phag_pkg::SAMPLE_W-1:0]   n_entry;
    logic                            n_above;
    logic                            n_hang_exp;
    logic                            n_attack;
    logic                            n_accept;
    logic                            n_out_free;
    logic [phag_pkg::GAIN_W-1:0]     n_clamped;
    logic                            n_mul_start;
    logic [phag_pkg::RAMP_W-1:0]     n_mplier;
    logic                            n_div_start;

    phag_pkg::t_unit_st              mul_st;
    phag_pkg::t_unit_st              div_st;
    logic [phag_pkg::PROD_W-1:0]     mul_product;
    logic [phag_pkg::GAIN_W-1:0]     div_quotient;

    assign n_len = (r_win_len == '0) ? phag_pkg::LEN_W'(1) :
                   (r_win_len > phag_pkg::LEN_W'(phag_pkg::WINDOW_DEPTH)) ?
                   phag_pkg::LEN_W'(phag_pkg::WINDOW_DEPTH) : r_win_len;
    assign n_widx_inc = {1'b0, r_widx} + phag_pkg::LEN_W'(1);
    assign n_entry    = r_window[r_scan];
    assign n_above    = (n_entry > r_nominal);
    assign n_hang_exp = (r_hang >= r_hang_ticks);
    assign n_attack   = (r_above == r_len) || ((r_above != '0) && n_hang_exp);
    assign n_accept   = i_in_valid && o_in_ready;
    assign n_out_free = !r_out_valid || i_out_ready;
    assign n_clamped  = (r_ext > {{(phag_pkg::GAIN_EXT_W - phag_pkg::GAIN_W){1'b0}},
                                  r_gain_limit}) ? r_gain_limit
                                                 : r_ext[phag_pkg::GAIN_W-1:0];

    assign n_mul_start = ((r_state == phag_pkg::ST_DECIDE) && n_attack) ||
                         ((r_state == phag_pkg::ST_RAMP) && n_hang_exp);
    assign n_mplier    = (r_state == phag_pkg::ST_DECIDE) ?
                         {{(phag_pkg::RAMP_W - phag_pkg::SAMPLE_W){1'b0}}, r_nominal} : r_ramp;
    assign n_div_start = (r_state == phag_pkg::ST_MULN) && mul_st.done;

    phag_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (n_mul_start),
        .i_mcand   (r_gain),
        .i_mplier  (n_mplier),
        .o_st      (mul_st),
        .o_product (mul_product)
    );

    phag_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (mul_product[phag_pkg::DIVIDEND_W-1:0]),
        .i_divisor  (r_max),
        .o_st       (div_st),
        .o_quotient (div_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal    <= phag_pkg::NOMINAL_RST;
            r_win_len    <= phag_pkg::WIN_LEN_RST;
            r_hang_ticks <= phag_pkg::HANG_TICKS_RST;
            r_ramp       <= phag_pkg::RAMP_RST;
            r_gain_limit <= phag_pkg::GAIN_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                phag_pkg::CFG_NOMINAL: begin
                    r_nominal <= i_cfg_data[phag_pkg::SAMPLE_W-1:0];
                end
                phag_pkg::CFG_WIN_LEN: begin
                    r_win_len <= i_cfg_data[phag_pkg::LEN_W-1:0];
                end
                phag_pkg::CFG_HANG_TICKS: begin
                    r_hang_ticks <= i_cfg_data[phag_pkg::HANG_W-1:0];
                end
                phag_pkg::CFG_RAMP: begin
                    r_ramp <= i_cfg_data[phag_pkg::RAMP_W-1:0];
                end
                phag_pkg::CFG_GAIN_LIMIT: begin
                    r_gain_limit <= i_cfg_data[phag_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= phag_pkg::ST_IDLE;
            r_gain      <= phag_pkg::GAIN_RST;
            r_widx      <= '0;
            r_hang      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < phag_pkg::WINDOW_DEPTH; k++) begin
                r_window[k] <= '0;
            end
        end else begin
            if (r_out_valid && i_out_ready && (r_state != phag_pkg::ST_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                phag_pkg::ST_IDLE: begin
                    if (n_accept) begin
                        r_window[r_widx] <= i_peak_sample;
                        r_widx   <= (n_widx_inc >= n_len) ? '0
                                    : n_widx_inc[phag_pkg::IDX_W-1:0];
                        r_len    <= n_len;
                        r_sample <= i_peak_sample;
                        r_scan   <= '0;
                        r_above  <= '0;
                        r_max    <= '0;
                        r_state  <= phag_pkg::ST_SCAN;
                    end
                end
                phag_pkg::ST_SCAN: begin
                    r_above <= r_above + phag_pkg::LEN_W'(n_above);
                    if (n_entry > r_max) begin
                        r_max <= n_entry;
                    end
                    if (({1'b0, r_scan} + phag_pkg::LEN_W'(1)) == r_len) begin
                        r_state <= phag_pkg::ST_DECIDE;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                phag_pkg::ST_DECIDE: begin
                    r_reduced <= n_attack;
                    if (n_attack) begin
                        r_hang  <= '0;
                        r_state <= phag_pkg::ST_MULN;
                    end else begin
                        if ((r_sample < r_nominal) && (r_hang != phag_pkg::HANG_MAX)) begin
                            r_hang <= r_hang + 1'b1;
                        end
                        r_state <= phag_pkg::ST_RAMP;
                    end
                end
                phag_pkg::ST_MULN: begin
                    if (mul_st.done) begin
                        r_state <= phag_pkg::ST_DIV;
                    end
                end
                phag_pkg::ST_DIV: begin
                    if (div_st.done) begin
                        r_gain  <= div_quotient;
                        r_state <= phag_pkg::ST_RAMP;
                    end
                end
                phag_pkg::ST_RAMP: begin
                    r_ramped <= n_hang_exp;
                    if (n_hang_exp) begin
                        r_state <= phag_pkg::ST_MULR;
                    end else begin
                        r_ext   <= {{(phag_pkg::GAIN_EXT_W - phag_pkg::GAIN_W){1'b0}}, r_gain};
                        r_state <= phag_pkg::ST_FIN;
                    end
                end
                phag_pkg::ST_MULR: begin
                    if (mul_st.done) begin
                        r_ext   <= mul_product[phag_pkg::PROD_W-1:phag_pkg::RAMP_SHIFT];
                        r_state <= phag_pkg::ST_FIN;
                    end
                end
                phag_pkg::ST_FIN: begin
                    if (n_out_free) begin
                        r_gain        <= n_clamped;
                        r_out_gain    <= n_clamped;
                        r_out_reduced <= r_reduced;
                        r_out_ramped  <= r_ramped;
                        r_out_valid   <= 1'b1;
                        r_state       <= phag_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= phag_pkg::ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == phag_pkg::ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_gain_out     = r_out_gain;
    assign o_gain_reduced = r_out_reduced;
    assign o_gain_ramped  = r_out_ramped;

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_st.busy && div_st.busy))
        else $error("Multiplier and divider are busy at the same time.");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |=> (r_state == phag_pkg::ST_SCAN))
        else $error("An accepted transaction did not start the window scan.");

    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_st.done |-> ((r_state == phag_pkg::ST_MULN) || (r_state == phag_pkg::ST_MULR)))
        else $error("Multiplier finished outside a multiply state.");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_st.done |-> (r_state == phag_pkg::ST_DIV))
        else $error("Divider finished outside the divide state.");

endmodule

// ===== dv/peak_hang_agc_gain_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak-hang AGC gain checker
// Watches the register port and both transaction channels of the peak-hang
// gain block. It keeps its own copy of the registers, the peak window, the
// hang count and the gain, works out the gain result for every accepted
// peak sample, and compares each accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module peak_hang_agc_gain_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [phag_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [phag_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [phag_pkg::SAMPLE_W-1:0]   i_peak_sample,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [phag_pkg::GAIN_W-1:0]     i_gain_out,
    input  logic                            i_gain_reduced,
    input  logic                            i_gain_ramped,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_results,
    output int                              o_cuts,
    output int                              o_ramps
);

    typedef struct packed {
        logic [phag_pkg::GAIN_W-1:0] gain;
        logic                        cut;
        logic                        ramp;
    } t_gain_result;

    logic [phag_pkg::SAMPLE_W-1:0] nominal_q;
    logic [phag_pkg::LEN_W-1:0]    win_len_q;
    logic [phag_pkg::HANG_W-1:0]   hang_ticks_q;
    logic [phag_pkg::RAMP_W-1:0]   ramp_q;
    logic [phag_pkg::GAIN_W-1:0]   limit_q;

    logic [phag_pkg::GAIN_W-1:0]   gain_q;
    logic [phag_pkg::SAMPLE_W-1:0] peak_hist [phag_pkg::WINDOW_DEPTH];
    int                            win_ptr;
    int                            hang_cnt;

    t_gain_result                  pending_gains [$];
    int                            err_count = 0;
    int                            result_count = 0;
    int                            cut_count = 0;
    int                            ramp_count = 0;
    int                            pending_n = 0;

    assign o_errors  = err_count;
    assign o_pending = pending_n;
    assign o_results = result_count;
    assign o_cuts    = cut_count;
    assign o_ramps   = ramp_count;

    task automatic report_mismatch(input string what, input longint want, input longint got);
        if (err_count < 40) begin
            $display("%0t ns: mismatch on result %0d, %s: expected %0d, got %0d",
                     $time, result_count, what, want, got);
        end
        err_count++;
    endtask

    function automatic t_gain_result next_gain(input logic [phag_pkg::SAMPLE_W-1:0] sample);
        int                            n;
        int                            above;
        int                            j;
        logic [phag_pkg::SAMPLE_W-1:0] peak_max;
        logic [63:0]                   g;
        t_gain_result                  r;
        n = win_len_q;
        if (n < 1) n = 1;
        if (n > phag_pkg::WINDOW_DEPTH) n = phag_pkg::WINDOW_DEPTH;
        peak_hist[win_ptr] = sample;
        win_ptr++;
        if (win_ptr >= n) win_ptr = 0;
        above = 0;
        peak_max = '0;
        for (j = 0; j < n; j++) begin
            if (peak_hist[j] > nominal_q) above++;
            if (peak_hist[j] > peak_max) peak_max = peak_hist[j];
        end
        g = 64'(gain_q);
        r.cut = 1'b0;
        r.ramp = 1'b0;
        if (above == n || (above > 0 && hang_cnt >= int'(hang_ticks_q))) begin
            if (peak_max != 0) g = (g * 64'(nominal_q)) / 64'(peak_max);
            hang_cnt = 0;
            r.cut = 1'b1;
        end else if (sample < nominal_q) begin
            if (hang_cnt < int'(phag_pkg::HANG_MAX)) hang_cnt++;
        end
        if (hang_cnt >= int'(hang_ticks_q)) begin
            g = (g * 64'(ramp_q)) >> phag_pkg::RAMP_SHIFT;
            r.ramp = 1'b1;
        end
        if (g > 64'(limit_q)) g = 64'(limit_q);
        gain_q = g[phag_pkg::GAIN_W-1:0];
        r.gain = gain_q;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_gain_result want;
        if (!i_rst_n) begin
            nominal_q    = phag_pkg::NOMINAL_RST;
            win_len_q    = phag_pkg::WIN_LEN_RST;
            hang_ticks_q = phag_pkg::HANG_TICKS_RST;
            ramp_q       = phag_pkg::RAMP_RST;
            limit_q      = phag_pkg::GAIN_LIMIT_RST;
            gain_q       = phag_pkg::GAIN_RST;
            foreach (peak_hist[k]) peak_hist[k] = '0;
            win_ptr      = 0;
            hang_cnt     = 0;
            pending_gains.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    phag_pkg::CFG_NOMINAL:
                        nominal_q    = i_cfg_data[phag_pkg::SAMPLE_W-1:0];
                    phag_pkg::CFG_WIN_LEN:
                        win_len_q    = i_cfg_data[phag_pkg::LEN_W-1:0];
                    phag_pkg::CFG_HANG_TICKS:
                        hang_ticks_q = i_cfg_data[phag_pkg::HANG_W-1:0];
                    phag_pkg::CFG_RAMP:
                        ramp_q       = i_cfg_data[phag_pkg::RAMP_W-1:0];
                    phag_pkg::CFG_GAIN_LIMIT:
                        limit_q      = i_cfg_data[phag_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                pending_gains.push_back(next_gain(i_peak_sample));
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_gains.size() == 0) begin
                    report_mismatch("result with no sample outstanding", 0, 1);
                end else begin
                    want = pending_gains.pop_front();
                    if (i_gain_out !== want.gain) begin
                        report_mismatch("gain_out", want.gain, i_gain_out);
                    end
                    if (i_gain_reduced !== want.cut) begin
                        report_mismatch("gain_reduced", want.cut, i_gain_reduced);
                    end
                    if (i_gain_ramped !== want.ramp) begin
                        report_mismatch("gain_ramped", want.ramp, i_gain_ramped);
                    end
                    if (want.cut) cut_count++;
                    if (want.ramp) ramp_count++;
                end
                result_count++;
            end
        end
        pending_n = pending_gains.size();
    end

endmodule

// ===== dv/tb_peak_hang_agc_gain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak-hang AGC gain testbench
// Feeds peak samples to the gain block under a series of register settings:
// a short directed set of edge values and corner cases, then bursts of loud
// peaks between quiet stretches with random content and some noise. Both
// channels idle at random, with a long output stall and a full drain thrown
// in. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_peak_hang_agc_gain;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [phag_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [phag_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic [phag_pkg::SAMPLE_W-1:0]   peak_sample;
    logic                            out_valid;
    logic                            out_ready;
    logic [phag_pkg::GAIN_W-1:0]     gain_out;
    logic                            gain_reduced;
    logic                            gain_ramped;

    int errors;
    int pending;
    int results;
    int cuts;
    int ramps;

    bit flow_free = 1'b0;
    int long_hold = 0;
    int cur_nom;
    int cur_hang;
    int quiet_left = 0;
    int loud_left = 0;
    int samples_sent = 0;
    int settings_used = 0;

    logic [phag_pkg::SAMPLE_W-1:0] reset_peaks [11] =
        '{16'd0, 16'd32768, 16'd32767, 16'd16384, 16'd16385, 16'd16383,
          16'd1, 16'd21845, 16'd10922, 16'd0, 16'd0};
    logic [phag_pkg::SAMPLE_W-1:0] coincide_peaks [4] =
        '{16'd20000, 16'd0, 16'd32768, 16'd100};
    logic [phag_pkg::SAMPLE_W-1:0] wide_peaks [5] =
        '{16'd9000, 16'd9000, 16'd100, 16'd100, 16'd9500};

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    peak_hang_agc_gain i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_peak_sample  (peak_sample),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_gain_out     (gain_out),
        .o_gain_reduced (gain_reduced),
        .o_gain_ramped  (gain_ramped)
    );

    peak_hang_agc_gain_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_peak_sample  (peak_sample),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_gain_out     (gain_out),
        .i_gain_reduced (gain_reduced),
        .i_gain_ramped  (gain_ramped),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_results      (results),
        .o_cuts         (cuts),
        .o_ramps        (ramps)
    );

    task automatic send_peak(input logic [phag_pkg::SAMPLE_W-1:0] value);
        int gap;
        gap = flow_free ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        peak_sample <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        samples_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_regs(input int nom, input int len, input int hang,
                              input int ramp, input int limit);
        cfg_we   <= 1'b1;
        cfg_idx  <= phag_pkg::CFG_NOMINAL;
        cfg_data <= phag_pkg::CFG_DATA_W'(nom);
        @(negedge clk);
        cfg_idx  <= phag_pkg::CFG_WIN_LEN;
        cfg_data <= phag_pkg::CFG_DATA_W'(len);
        @(negedge clk);
        cfg_idx  <= phag_pkg::CFG_HANG_TICKS;
        cfg_data <= phag_pkg::CFG_DATA_W'(hang);
        @(negedge clk);
        cfg_idx  <= phag_pkg::CFG_RAMP;
        cfg_data <= phag_pkg::CFG_DATA_W'(ramp);
        @(negedge clk);
        cfg_idx  <= phag_pkg::CFG_GAIN_LIMIT;
        cfg_data <= phag_pkg::CFG_DATA_W'(limit);
        @(negedge clk);
        cfg_we   <= 1'b0;
        cur_nom  = nom;
        cur_hang = hang;
        settings_used++;
    endtask

    task automatic run_traffic(input int count, input bit pause_midway);
        int                            k;
        int                            lo;
        int                            hi;
        logic [phag_pkg::SAMPLE_W-1:0] pk;
        for (k = 0; k < count; k++) begin
            if (pause_midway && k == count / 2) drain();
            if ($urandom_range(0, 9) == 0) begin
                pk = $urandom_range(0, 32768);
            end else begin
                if (quiet_left == 0 && loud_left == 0) begin
                    loud_left  = $urandom_range(1, 4);
                    quiet_left = $urandom_range(0, (cur_hang > 60 ? 60 : cur_hang) + 20);
                end
                if (loud_left > 0) begin
                    loud_left--;
                    lo = (cur_nom + 1 > 32768) ? 32768 : cur_nom + 1;
                    hi = (cur_nom + cur_nom / 2 + 1 > 32768) ? 32768 : cur_nom + cur_nom / 2 + 1;
                    pk = $urandom_range(lo, hi);
                end else begin
                    if (quiet_left > 0) quiet_left--;
                    pk = $urandom_range(0, cur_nom);
                end
            end
            send_peak(pk);
        end
    endtask

    initial begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        out_ready <= 1'b1;
        forever begin
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
            stall = flow_free ? 0 : $urandom_range(0, 10);
            if (long_hold > 0) begin
                stall     = long_hold;
                long_hold = 0;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int p;
        int nom;
        int len;
        int hang;
        int ramp;
        int limit;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_idx     = phag_pkg::CFG_NOMINAL;
        cfg_data    = '0;
        in_valid    = 1'b0;
        peak_sample = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        cur_nom  = phag_pkg::NOMINAL_RST;
        cur_hang = phag_pkg::HANG_TICKS_RST;

        foreach (reset_peaks[i]) send_peak(reset_peaks[i]);
        drain();
        // With no hang time an attack cut and a ramp land on the same sample.
        write_regs(16384, 1, 0, 131072, 33554432);
        foreach (coincide_peaks[i]) send_peak(coincide_peaks[i]);
        drain();
        // Leave the window index at 5, then shrink the window to 3 entries.
        write_regs(8000, 8, 4, 68813, 33554432);
        foreach (wide_peaks[i]) send_peak(wide_peaks[i]);
        drain();
        write_regs(8000, 3, 4, 68813, 33554432);
        send_peak(16'd100);
        send_peak(16'd9000);

        for (p = 0; p < 9; p++) begin
            drain();
            nom   = $urandom_range(4096, 30000);
            len   = $urandom_range(1, 8);
            hang  = $urandom_range(0, 40);
            ramp  = $urandom_range(68000, 131072);
            limit = $urandom_range(1 << 22, 1 << 25);
            case (p)
                0: begin
                    ramp  = 131072;
                    limit = 33554432;
                end
                1: nom  = 32768;
                2: len  = 0;
                5: len  = 15;
                6: hang = 65535;
                8: ramp = 65536;
                default: ;
            endcase
            flow_free = (p == 3 || p == 7);
            if (p == 4) long_hold = 300;
            write_regs(nom, len, hang, ramp, limit);
            run_traffic(135, p == 6);
        end
        flow_free = 1'b0;

        // These settings can pin the gain at zero, so they come last.
        drain();
        write_regs(1, 8, 3, 65536, 1);
        run_traffic(40, 1'b0);
        drain();
        write_regs(16384, 4, 0, 100000, 0);
        run_traffic(30, 1'b0);
        drain();
        repeat (100) @(negedge clk);

        $display("Covered %0d peak samples under %0d register settings, with idle gaps,",
                 samples_sent, settings_used);
        $display("a long output stall and a full drain; %0d results, %0d cuts, %0d ramps.",
                 results, cuts, ramps);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #25_000_000;
        $display("Timed out with %0d results still outstanding.", pending);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
